// ----- rtl/core/keyed_slot_allocator_top_macros.svh -----
// Assertion macros for the keyed slot allocator
`ifndef KEYED_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define KEYED_SLOT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define KSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator check failed");

// next-cycle implication
`define KSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator sequence check failed");

`endif

// ----- rtl/core/ksa_pkg.sv -----
// Shared types and constants for the keyed slot allocator
package ksa_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int CFG_W          = 7;
    localparam int CNT_W          = 32;
    localparam int RESET_SLOTS    = 64;
    localparam int MAX_MANAGED    = 127;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [6:0]       slot_number;
        logic [6:0]       free_slots;
        logic [CNT_W-1:0] alloc_ok_count;
        logic [CNT_W-1:0] alloc_fail_count;
        logic [CNT_W-1:0] release_fail_count;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic clear_all;
        logic set_slot;
        logic free_slot;
        logic rd_en;
        logic alloc_mode;
    } tbl_ctrl_t;

    typedef struct packed {
        logic vld;
        logic hit;
    } probe_t;

endpackage

// ----- rtl/core/ksa_table.sv -----
// Slot table: valid bits, key memory and the shared per-slot compare stage
module ksa_table #(
    parameter int VN = 64,
    parameter int IW = 6,
    parameter int KW = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ksa_pkg::tbl_ctrl_t ctrl,
    input  logic [IW-1:0]     upd_idx,
    input  logic [KW-1:0]     wr_key,
    input  logic [IW-1:0]     rd_addr,
    input  logic [KW-1:0]     probe_key,
    output ksa_pkg::probe_t   probe,
    output logic [IW-1:0]     probe_idx
);

    logic [VN-1:0] valid_reg;
    logic [VN-1:0] valid_next;
    logic [KW-1:0] key_mem [VN];
    logic [KW-1:0] rd_key_reg;
    logic          cmp_vld_reg;
    logic [IW-1:0] cmp_idx_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear_all)
        begin
            valid_next = '0;
        end
        else if (ctrl.set_slot)
        begin
            valid_next[upd_idx] = 1'b1;
        end
        else if (ctrl.free_slot)
        begin
            valid_next[upd_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            cmp_vld_reg <= ctrl.rd_en;
        end
    end

    // key memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.set_slot)
        begin
            key_mem[upd_idx] <= wr_key;
        end
        if (ctrl.rd_en)
        begin
            rd_key_reg  <= key_mem[rd_addr];
            cmp_idx_reg <= rd_addr;
        end
    end

    always_comb
    begin
        probe.vld = cmp_vld_reg;
        if (ctrl.alloc_mode)
        begin
            probe.hit = !valid_reg[cmp_idx_reg];
        end
        else
        begin
            probe.hit = valid_reg[cmp_idx_reg] && (rd_key_reg == probe_key);
        end
    end

    assign probe_idx = cmp_idx_reg;

endmodule

// ----- rtl/core/keyed_slot_allocator_top.sv -----
// Keyed slot allocator: first-fit allocate and keyed release over a slot table
// A command scans the managed slots in order from slot 0 and stops at the first hit;
// a miss scans every managed slot. The result is registered in the update state.
// An allocate with no free slot skips the scan. One slot is compared per cycle
// through the single key memory read port, so busy stays high for the whole scan.
// Reset frees every slot, clears the counters and manages min(64, SLOT_COUNT) slots.
// Results are one-cycle strobes on done; the receiver cannot stall them.
`include "keyed_slot_allocator_top_macros.svh"

module keyed_slot_allocator_top #(
    parameter int SLOT_COUNT = ksa_pkg::SLOT_COUNT_DEF,
    parameter int KEY_BITS   = ksa_pkg::KEY_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  ksa_pkg::req_t             req,
    output logic                      done,
    output ksa_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  logic [ksa_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int VN = (SLOT_COUNT < ksa_pkg::MAX_MANAGED) ? SLOT_COUNT
                                                             : ksa_pkg::MAX_MANAGED;
    localparam int IW = (VN > 1) ? $clog2(VN) : 1;
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam logic [ksa_pkg::CFG_W-1:0] RESET_N =
        ksa_pkg::CFG_W'((ksa_pkg::RESET_SLOTS < SLOT_COUNT) ? ksa_pkg::RESET_SLOTS
                                                             : SLOT_COUNT);
    localparam logic [ksa_pkg::CFG_W-1:0] MAX_N = ksa_pkg::CFG_W'(VN);

    ksa_pkg::state_t state_reg;
    ksa_pkg::state_t state_next;

    logic [6:0]                n_reg;
    logic [6:0]                n_next;
    logic [6:0]                free_reg;
    logic [6:0]                free_next;
    logic [ksa_pkg::CNT_W-1:0] ok_reg;
    logic [ksa_pkg::CNT_W-1:0] ok_next;
    logic [ksa_pkg::CNT_W-1:0] full_reg;
    logic [ksa_pkg::CNT_W-1:0] full_next;
    logic [ksa_pkg::CNT_W-1:0] miss_reg;
    logic [ksa_pkg::CNT_W-1:0] miss_next;
    logic                      cmd_reg;
    logic [KW-1:0]             key_reg;
    logic [IW-1:0]             scan_addr_reg;
    logic                      issue_reg;
    logic                      found_reg;
    logic [IW-1:0]             hit_idx_reg;
    logic                      done_reg;
    ksa_pkg::rsp_t             rsp_reg;
    ksa_pkg::rsp_t             rsp_next;

    ksa_pkg::tbl_ctrl_t        ctrl;
    ksa_pkg::probe_t           probe;
    logic [IW-1:0]             probe_idx;
    logic [6:0]                last_idx;
    logic                      accept;
    logic                      scan_end;

    assign accept   = start && !busy;
    assign last_idx = n_reg - 7'd1;
    assign scan_end = probe.vld && (probe.hit || (7'(probe_idx) == last_idx));

    ksa_table #(
        .VN (VN),
        .IW (IW),
        .KW (KW)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .upd_idx   (hit_idx_reg),
        .wr_key    (key_reg),
        .rd_addr   (scan_addr_reg),
        .probe_key (key_reg),
        .probe     (probe),
        .probe_idx (probe_idx)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ksa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if ((req.cmd == ksa_pkg::CMD_ALLOC) && (free_reg == 7'd0))
                    begin
                        state_next = ksa_pkg::S_UPDATE;
                    end
                    else
                    begin
                        state_next = ksa_pkg::S_SCAN;
                    end
                end
            end
            ksa_pkg::S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ksa_pkg::S_UPDATE;
                end
            end
            ksa_pkg::S_UPDATE:
            begin
                state_next = ksa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ksa_pkg::S_IDLE;
            end
        endcase
    end

    // outputs to the table
    always_comb
    begin
        busy            = (state_reg != ksa_pkg::S_IDLE);
        ctrl.clear_all  = cfg_we;
        ctrl.rd_en      = (state_reg == ksa_pkg::S_SCAN) && issue_reg;
        ctrl.alloc_mode = (cmd_reg == ksa_pkg::CMD_ALLOC);
        ctrl.set_slot   = (state_reg == ksa_pkg::S_UPDATE) && found_reg &&
                          (cmd_reg == ksa_pkg::CMD_ALLOC);
        ctrl.free_slot  = (state_reg == ksa_pkg::S_UPDATE) && found_reg &&
                          (cmd_reg == ksa_pkg::CMD_RELEASE);
    end

    // clamp the written slot count
    always_comb
    begin
        n_next = cfg_wdata;
        if (cfg_wdata == 7'd0)
        begin
            n_next = 7'd1;
        end
        else if (32'(cfg_wdata) > SLOT_COUNT)
        begin
            n_next = MAX_N;
        end
    end

    // result of the finished command
    always_comb
    begin
        free_next = free_reg;
        ok_next   = ok_reg;
        full_next = full_reg;
        miss_next = miss_reg;
        rsp_next.status      = ksa_pkg::ST_OK;
        rsp_next.slot_number = 7'd0;
        if (cmd_reg == ksa_pkg::CMD_ALLOC)
        begin
            if (found_reg)
            begin
                free_next = free_reg - 7'd1;
                ok_next   = (ok_reg == ksa_pkg::CNT_MAX) ? ok_reg : ok_reg + 1'b1;
                rsp_next.slot_number = 7'(hit_idx_reg) + 7'd1;
            end
            else
            begin
                full_next = (full_reg == ksa_pkg::CNT_MAX) ? full_reg : full_reg + 1'b1;
                rsp_next.status = ksa_pkg::ST_FULL;
            end
        end
        else
        begin
            if (found_reg)
            begin
                free_next = free_reg + 7'd1;
            end
            else
            begin
                miss_next = (miss_reg == ksa_pkg::CNT_MAX) ? miss_reg : miss_reg + 1'b1;
                rsp_next.status = ksa_pkg::ST_MISS;
            end
        end
        rsp_next.free_slots         = free_next;
        rsp_next.alloc_ok_count     = ok_next;
        rsp_next.alloc_fail_count   = full_next;
        rsp_next.release_fail_count = miss_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ksa_pkg::S_IDLE;
            n_reg         <= RESET_N;
            free_reg      <= RESET_N;
            ok_reg        <= '0;
            full_reg      <= '0;
            miss_reg      <= '0;
            issue_reg     <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
            scan_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ksa_pkg::S_UPDATE);
            if (cfg_we)
            begin
                n_reg    <= n_next;
                free_reg <= n_next;
                ok_reg   <= '0;
                full_reg <= '0;
                miss_reg <= '0;
            end
            else if (state_reg == ksa_pkg::S_UPDATE)
            begin
                free_reg <= free_next;
                ok_reg   <= ok_next;
                full_reg <= full_next;
                miss_reg <= miss_next;
            end
            if (accept)
            begin
                scan_addr_reg <= '0;
                issue_reg     <= 1'b1;
                found_reg     <= 1'b0;
            end
            else if (state_reg == ksa_pkg::S_SCAN)
            begin
                // advance the read address until the last managed slot
                if (ctrl.rd_en)
                begin
                    if (7'(scan_addr_reg) == last_idx)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                    end
                end
                if (probe.vld && probe.hit)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // payload: hold command, hit index and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            key_reg <= req.key[KW-1:0];
        end
        if ((state_reg == ksa_pkg::S_SCAN) && probe.vld && probe.hit)
        begin
            hit_idx_reg <= probe_idx;
        end
        if (state_reg == ksa_pkg::S_UPDATE)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `KSA_ASSERT_NEXT(a_accept_busy, accept, busy)
    `KSA_ASSERT_NOW(a_done_idle, done_reg, state_reg == ksa_pkg::S_IDLE)
    `KSA_ASSERT_NOW(a_free_bound, 1'b1, free_reg <= n_reg)
    `KSA_ASSERT_NOW(a_fail_no_slot, done_reg && (rsp_reg.status != ksa_pkg::ST_OK),
                    rsp_reg.slot_number == 7'd0)
    `KSA_ASSERT_NOW(a_status_legal, done_reg,
                    (rsp_reg.status == ksa_pkg::ST_OK) || (rsp_reg.status == ksa_pkg::ST_FULL) ||
                    (rsp_reg.status == ksa_pkg::ST_MISS))

endmodule
